### rtl/core/awbs_pkg.sv
// ----------------------------------------------------------------------------
// awbs_pkg
// Shared constants and types for the affine warp bilinear sampler.
// ----------------------------------------------------------------------------
package awbs_pkg;

  localparam int MaxWidth  = 512;
  localparam int MaxHeight = 512;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  // mirror index width, covers both axes
  localparam int IdxW      = (ColW > RowW) ? ColW : RowW;
  localparam int AddrW     = ColW + RowW;
  localparam int Depth     = MaxWidth * MaxHeight;
  // source position, Q.16, signed; covers 20x10 products, three terms
  localparam int PosW      = 34;

  localparam logic [2:0] RegMatXx   = 3'd0;
  localparam logic [2:0] RegMatXy   = 3'd1;
  localparam logic [2:0] RegMatYx   = 3'd2;
  localparam logic [2:0] RegMatYy   = 3'd3;
  localparam logic [2:0] RegShiftX  = 3'd4;
  localparam logic [2:0] RegShiftY  = 3'd5;
  localparam logic [2:0] RegWidth   = 3'd6;
  localparam logic [2:0] RegHeight  = 3'd7;

endpackage

### rtl/core/awbs_ram.sv
// ----------------------------------------------------------------------------
// awbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module awbs_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/awbs_mirror.sv
// ----------------------------------------------------------------------------
// awbs_mirror
// Whole-sample mirror of a neighbor index pair into 0..n-1.
// ----------------------------------------------------------------------------
module awbs_mirror (
  input  logic signed [awbs_pkg::IdxW+2:0] idx,
  input  logic        [awbs_pkg::IdxW:0]   n,
  output logic        [awbs_pkg::IdxW-1:0] i0,
  output logic        [awbs_pkg::IdxW-1:0] i1
);

  localparam int IW = awbs_pkg::IdxW;

  function automatic logic [IW-1:0] mir(input logic signed [IW+2:0] i,
                                        input logic [IW:0] nn);
    logic signed [IW+2:0] v;
    logic signed [IW+2:0] ns;
    begin
      ns = $signed({2'b00, nn});
      v  = (i < 0) ? -i : i;
      if (v >= ns) v = ((ns - 1) <<< 1) - v;
      if (v < 0) v = '0;
      if (v >= ns) v = ns - 1;
      mir = v[IW-1:0];
    end
  endfunction

  assign i0 = mir(idx, n);
  assign i1 = mir(idx + $signed((IW+3)'(1)), n);

endmodule

### rtl/core/affine_warp_bilinear_sampler_unit.sv
// ----------------------------------------------------------------------------
// affine_warp_bilinear_sampler_unit
// Affine warp of a stored 8-bit frame with bilinear interpolation.
//
//   channel  ports                              transaction
//   in       start/busy, in_kind/col/row/pixel  start & !busy
//   out      out_strobe, out_sample/valid_res   out_strobe, one cycle
//   cfg      cfg_we, cfg_index, cfg_data        cfg_we
//
// One item per clock; busy is always low. A request passes through the affine
// products and sums, range and mirror, the four frame reads (four RAM copies,
// one per neighbor), the blend multiplies and the output register.
// Writes go to all copies, delayed to stay in order with reads.
// Reset is synchronous; the frame is undefined until written.
// ----------------------------------------------------------------------------
module affine_warp_bilinear_sampler_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [8:0]  in_col,
  input  logic [8:0]  in_row,
  input  logic [7:0]  in_pixel,
  output logic        out_strobe,
  output logic [15:0] out_sample,
  output logic        out_valid_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int PW = awbs_pkg::PosW;
  localparam int CW = awbs_pkg::ColW;
  localparam int RW = awbs_pkg::RowW;
  localparam int IW = awbs_pkg::IdxW;

  logic signed [19:0] mxx_r, mxy_r, myx_r, myy_r;
  logic signed [18:0] shx_r, shy_r;
  logic [9:0] fw_r, fh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mxx_r <= 20'sd65536; mxy_r <= '0; myx_r <= '0; myy_r <= 20'sd65536;
      shx_r <= '0; shy_r <= '0; fw_r <= 10'd512; fh_r <= 10'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        awbs_pkg::RegMatXx:  mxx_r <= cfg_data;
        awbs_pkg::RegMatXy:  mxy_r <= cfg_data;
        awbs_pkg::RegMatYx:  myx_r <= cfg_data;
        awbs_pkg::RegMatYy:  myy_r <= cfg_data;
        awbs_pkg::RegShiftX: shx_r <= cfg_data[18:0];
        awbs_pkg::RegShiftY: shy_r <= cfg_data[18:0];
        awbs_pkg::RegWidth:  fw_r  <= cfg_data[9:0];
        awbs_pkg::RegHeight: fh_r  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // clamped sizes
  logic [CW:0] w_c;
  logic [RW:0] h_c;
  always_comb begin
    if (fw_r < 10'd3) w_c = (CW+1)'(3);
    else if (fw_r > 10'(awbs_pkg::MaxWidth)) w_c = (CW+1)'(awbs_pkg::MaxWidth);
    else w_c = (CW+1)'(fw_r);
    if (fh_r < 10'd3) h_c = (RW+1)'(3);
    else if (fh_r > 10'(awbs_pkg::MaxHeight)) h_c = (RW+1)'(awbs_pkg::MaxHeight);
    else h_c = (RW+1)'(fh_r);
  end

  assign busy = 1'b0;
  logic acc_in;
  assign acc_in = start & ~busy;

  // write path, delayed to stay in order with reads
  logic wr_v;
  logic [awbs_pkg::AddrW-1:0] wr_a;
  assign wr_v = acc_in & ~in_kind;
  assign wr_a = {in_row, in_col};

  logic [3:0] wv_r;
  logic [awbs_pkg::AddrW-1:0] wa_r [4];
  logic [7:0] wd_r [4];
  always_ff @(posedge clk) begin
    if (!rst_n) wv_r <= '0;
    else wv_r <= {wv_r[2:0], wr_v};
    wa_r[0] <= wr_a;
    wd_r[0] <= in_pixel;
    for (int k = 1; k < 4; k++) begin
      wa_r[k] <= wa_r[k-1];
      wd_r[k] <= wd_r[k-1];
    end
  end

  // stage 1: products
  logic v1_r;
  logic signed [PW-1:0] pxa_r, pxb_r, pya_r, pyb_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= acc_in & in_kind;
    pxa_r <= PW'(mxx_r * $signed({1'b0, in_col}));
    pxb_r <= PW'(mxy_r * $signed({1'b0, in_row}));
    pya_r <= PW'(myx_r * $signed({1'b0, in_col}));
    pyb_r <= PW'(myy_r * $signed({1'b0, in_row}));
  end

  // stage 2: sums
  logic v2_r;
  logic signed [PW-1:0] px_r, py_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    px_r <= pxa_r + pxb_r + (PW'(shx_r) <<< 8) + PW'(131072);
    py_r <= pya_r + pyb_r + (PW'(shy_r) <<< 8) + PW'(131072);
  end

  // stage 3: range test, integer and fraction (px_r holds px + 2)
  logic v3_r, ok3_r;
  logic signed [IW+2:0] ix3_r;
  logic signed [IW+2:0] iy3_r;
  logic [15:0] fx3_r, fy3_r;
  logic okx, oky;
  assign okx = (px_r > 0) && (px_r < ($signed({{(PW-CW-1){1'b0}}, w_c}) + 3) <<< 16);
  assign oky = (py_r > 0) && (py_r < ($signed({{(PW-RW-1){1'b0}}, h_c}) + 3) <<< 16);
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
    ok3_r <= okx & oky;
    ix3_r <= (IW+3)'($signed(px_r[PW-1:16]) - 2);
    iy3_r <= (IW+3)'($signed(py_r[PW-1:16]) - 2);
    fx3_r <= px_r[15:0];
    fy3_r <= py_r[15:0];
  end

  // stage 4: mirror
  logic [IW-1:0] c0, c1;
  logic [IW-1:0] r0, r1;
  awbs_mirror u_mx (.idx(ix3_r), .n((IW+1)'(w_c)), .i0(c0), .i1(c1));
  awbs_mirror u_my (.idx(iy3_r), .n((IW+1)'(h_c)), .i0(r0), .i1(r1));

  logic v4_r, ok4_r;
  logic [15:0] fx4_r, fy4_r;
  logic [awbs_pkg::AddrW-1:0] a00_r, a01_r, a10_r, a11_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else v4_r <= v3_r;
    ok4_r <= ok3_r; fx4_r <= fx3_r; fy4_r <= fy3_r;
    a00_r <= {r0[RW-1:0], c0[CW-1:0]}; a01_r <= {r0[RW-1:0], c1[CW-1:0]};
    a10_r <= {r1[RW-1:0], c0[CW-1:0]}; a11_r <= {r1[RW-1:0], c1[CW-1:0]};
  end

  // stage 5: frame reads (write ordering: earlier writes have landed)
  logic [7:0] p00, p01, p10, p11;
  awbs_ram #(.Width(8), .Depth(awbs_pkg::Depth)) u_m00 (.clk(clk), .we(wv_r[3]),
    .waddr(wa_r[3]), .wdata(wd_r[3]), .raddr(a00_r), .rdata(p00));
  awbs_ram #(.Width(8), .Depth(awbs_pkg::Depth)) u_m01 (.clk(clk), .we(wv_r[3]),
    .waddr(wa_r[3]), .wdata(wd_r[3]), .raddr(a01_r), .rdata(p01));
  awbs_ram #(.Width(8), .Depth(awbs_pkg::Depth)) u_m10 (.clk(clk), .we(wv_r[3]),
    .waddr(wa_r[3]), .wdata(wd_r[3]), .raddr(a10_r), .rdata(p10));
  awbs_ram #(.Width(8), .Depth(awbs_pkg::Depth)) u_m11 (.clk(clk), .we(wv_r[3]),
    .waddr(wa_r[3]), .wdata(wd_r[3]), .raddr(a11_r), .rdata(p11));

  logic v5_r, ok5_r;
  logic [15:0] fx5_r, fy5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else v5_r <= v4_r;
    ok5_r <= ok4_r; fx5_r <= fx4_r; fy5_r <= fy4_r;
  end

  // stage 6: horizontal products
  logic [16:0] gx5;
  assign gx5 = 17'd65536 - {1'b0, fx5_r};
  logic v6_r, ok6_r;
  logic [15:0] fy6_r;
  logic [24:0] t0_r, t1_r, b0_r, b1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else v6_r <= v5_r;
    ok6_r <= ok5_r; fy6_r <= fy5_r;
    t0_r <= p00 * gx5; t1_r <= p01 * fx5_r;
    b0_r <= p10 * gx5; b1_r <= p11 * fx5_r;
  end

  // stage 7: horizontal sums
  logic v7_r, ok7_r;
  logic [15:0] fy7_r;
  logic [24:0] top_r, bot_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else v7_r <= v6_r;
    ok7_r <= ok6_r; fy7_r <= fy6_r;
    top_r <= t0_r + t1_r;
    bot_r <= b0_r + b1_r;
  end

  // stage 8: vertical products
  logic [16:0] gy7;
  assign gy7 = 17'd65536 - {1'b0, fy7_r};
  logic v8_r, ok8_r;
  logic [41:0] vt_r, vb_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else v8_r <= v7_r;
    ok8_r <= ok7_r;
    vt_r <= top_r * gy7;
    vb_r <= bot_r * fy7_r;
  end

  // stage 9: sum, round, output register
  logic [41:0] acc;
  assign acc = vt_r + vb_r + 42'd8388608;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
      out_valid_res <= 1'b0;
      out_sample <= '0;
    end else begin
      out_strobe <= v8_r;
      out_valid_res <= ok8_r;
      out_sample <= ok8_r ? acc[39:24] : 16'd0;
    end
  end

endmodule

### dv/tb_affine_warp_bilinear_sampler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_affine_warp_bilinear_sampler_unit
// Self-checking bench for the affine warp bilinear sampler. A directed table
// covers the frame corners, the edges of the valid range, clamped frame
// sizes and extreme registers. Random phases then reconfigure the block, fill
// small frames or scatter writes over large ones, and mix pixel writes with
// warp requests, checked by a bit-exact bilinear predictor or typed values.
// ----------------------------------------------------------------------------
module tb_affine_warp_bilinear_sampler_unit;

  typedef enum {DoWrite, DoRequest, DoConfig} op_t;
  typedef struct {
    op_t         op;
    int          a;
    int          b;
    logic [19:0] d;
    bit          typed;
    logic [15:0] t_sample;
    bit          t_valid;
  } row_t;
  typedef struct {
    logic [15:0] sample;
    bit          valid;
  } px_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_kind = 1'b0;
  logic [8:0] in_col = '0;
  logic [8:0] in_row = '0;
  logic [7:0] in_pixel = '0;
  logic out_strobe;
  logic [15:0] out_sample;
  logic out_valid_res;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = awbs_pkg::RegMatXx;
  logic [19:0] cfg_data = '0;

  affine_warp_bilinear_sampler_unit uut (.*);

  always #5 clk = ~clk;

  // frame mirror and register copies
  bit [7:0] frame_mem [awbs_pkg::Depth];
  bit       frame_set [awbs_pkg::Depth];
  longint   m_xx = 65536, m_xy = 0, m_yx = 0, m_yy = 65536, s_x = 0, s_y = 0;
  int       w_reg = 512, h_reg = 512;

  px_res_t  sample_q[$];
  bit          typed_q[$];
  px_res_t     typed_val_q[$];
  int errors = 0, n_req = 0, n_valid = 0, n_write = 0, n_cfg = 0, n_items = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  function automatic int clampi(int v, int hi);
    return (v < 3) ? 3 : (v > hi) ? hi : v;
  endfunction

  function automatic longint reflect(longint i, longint n);
    if (i < 0) i = -i;
    if (i >= n) i = 2 * (n - 1) - i;
    if (i < 0) i = 0;
    if (i >= n) i = n - 1;
    return i;
  endfunction

  function automatic void warp_pixel(input int col, input int row, output bit readable,
                                     output px_res_t res);
    longint w, h, px, py, ix, iy, fx, fy, c0, c1, r0, r1;
    longint unsigned top, bot, acc;
    w = clampi(w_reg, awbs_pkg::MaxWidth);
    h = clampi(h_reg, awbs_pkg::MaxHeight);
    px = m_xx * col + m_xy * row + s_x * 256;
    py = m_yx * col + m_yy * row + s_y * 256;
    readable = 1;
    res.sample = '0;
    res.valid = 0;
    if (!(px > -2 * 65536 && px < (w + 1) * 65536 && py > -2 * 65536 && py < (h + 1) * 65536))
      return;
    ix = ((px + 131072) >>> 16) - 2;
    iy = ((py + 131072) >>> 16) - 2;
    fx = (px + 131072) & 64'hFFFF;
    fy = (py + 131072) & 64'hFFFF;
    c0 = reflect(ix, w);
    c1 = reflect(ix + 1, w);
    r0 = reflect(iy, h);
    r1 = reflect(iy + 1, h);
    readable = frame_set[r0 * awbs_pkg::MaxWidth + c0] &&
               frame_set[r0 * awbs_pkg::MaxWidth + c1] &&
               frame_set[r1 * awbs_pkg::MaxWidth + c0] &&
               frame_set[r1 * awbs_pkg::MaxWidth + c1];
    top = frame_mem[r0 * awbs_pkg::MaxWidth + c0] * (65536 - fx) +
          frame_mem[r0 * awbs_pkg::MaxWidth + c1] * fx;
    bot = frame_mem[r1 * awbs_pkg::MaxWidth + c0] * (65536 - fx) +
          frame_mem[r1 * awbs_pkg::MaxWidth + c1] * fx;
    acc = top * (65536 - fy) + bot * fy;
    res.sample = 16'((acc + 64'd8388608) >> 24);
    res.valid = 1;
  endfunction

  // accept transactions, update the mirror, check results
  always @(posedge clk) begin
    bit rd;
    bit tflag;
    px_res_t pr, ex, tres;
    if (rst_n) begin
      if (start && !busy) begin
        idle_cycles = 0;
        n_items++;
        if (!in_kind) begin
          frame_mem[in_row * awbs_pkg::MaxWidth + in_col] = in_pixel;
          frame_set[in_row * awbs_pkg::MaxWidth + in_col] = 1;
          n_write++;
        end else begin
          warp_pixel(in_col, in_row, rd, pr);
          tflag = 0;
          tres = pr;
          if (typed_q.size() != 0) begin
            tflag = typed_q.pop_front();
            tres = typed_val_q.pop_front();
          end
          sample_q.push_back(tflag ? tres : pr);
          n_req++;
          if (pr.valid) n_valid++;
        end
      end
      if (cfg_we) begin
        idle_cycles = 0;
        n_cfg++;
        case (cfg_index)
          awbs_pkg::RegMatXx:  m_xx = $signed(cfg_data);
          awbs_pkg::RegMatXy:  m_xy = $signed(cfg_data);
          awbs_pkg::RegMatYx:  m_yx = $signed(cfg_data);
          awbs_pkg::RegMatYy:  m_yy = $signed(cfg_data);
          awbs_pkg::RegShiftX: s_x = $signed(cfg_data[18:0]);
          awbs_pkg::RegShiftY: s_y = $signed(cfg_data[18:0]);
          awbs_pkg::RegWidth:  w_reg = cfg_data[9:0];
          awbs_pkg::RegHeight: h_reg = cfg_data[9:0];
          default: ;
        endcase
      end
      if (out_strobe) begin
        idle_cycles = 0;
        if (sample_q.size() == 0) begin
          $error("unexpected result sample=%h valid_res=%b", out_sample, out_valid_res);
          errors++;
        end else begin
          ex = sample_q.pop_front();
          if (out_sample !== ex.sample) begin
            $error("sample: expected %h actual %h", ex.sample, out_sample);
            errors++;
          end
          if (out_valid_res !== ex.valid) begin
            $error("valid_res: expected %b actual %b", ex.valid, out_valid_res);
            errors++;
          end
        end
      end
      idle_cycles++;
      if (idle_cycles > 5000) begin
        $display("affine_warp_bilinear_sampler_unit verification failed");
        $finish;
      end
    end
  end

  task automatic send(bit kind, int col, int row, int pixel);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    start <= 1'b1;
    in_kind <= kind;
    in_col <= col[8:0];
    in_row <= row[8:0];
    in_pixel <= pixel[7:0];
    do @(posedge clk); while (busy);
  endtask

  // wait until quiet, covering writes still in flight
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    wait (sample_q.size() == 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [19:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
  endtask

  task automatic cfg_done();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [19:0] rand_mat();
    int v;
    if ($urandom_range(0, 3) == 0) return 20'($urandom);
    v = $urandom_range(0, 262144) - 131072;
    return 20'(v);
  endfunction

  function automatic logic [19:0] rand_shift(int span);
    int v;
    if ($urandom_range(0, 4) == 0) return 20'($urandom & 32'h7FFFF);
    v = $urandom_range(0, 2 * span * 256) - span * 256;
    return 20'(v & 32'h7FFFF);
  endfunction

  row_t dir_tbl[] = '{
    '{DoWrite,   0,   0,   20'hFF, 0, 16'h0, 0},
    '{DoWrite,   1,   0,   20'h00, 0, 16'h0, 0},
    '{DoWrite,   0,   1,   20'h00, 0, 16'h0, 0},
    '{DoWrite,   1,   1,   20'h00, 0, 16'h0, 0},
    '{DoRequest, 0,   0,   20'h0,  1, 16'hFF00, 1},
    '{DoWrite,   511, 511, 20'hAB, 0, 16'h0, 0},
    '{DoWrite,   510, 511, 20'h12, 0, 16'h0, 0},
    '{DoWrite,   511, 510, 20'h12, 0, 16'h0, 0},
    '{DoWrite,   510, 510, 20'h12, 0, 16'h0, 0},
    '{DoRequest, 511, 511, 20'h0,  1, 16'hAB00, 1},
    '{DoWrite,   2,   0,   20'h77, 0, 16'h0, 0},
    '{DoWrite,   2,   1,   20'hC4, 0, 16'h0, 0},
    '{DoConfig,  awbs_pkg::RegShiftX, 0, 20'h7FE01, 0, 16'h0, 0},
    '{DoRequest, 0,   0,   20'h0,  0, 16'h0, 0},
    '{DoConfig,  awbs_pkg::RegShiftX, 0, 20'h7FE00, 0, 16'h0, 0},
    '{DoRequest, 0,   0,   20'h0,  1, 16'h0, 0},
    '{DoConfig,  awbs_pkg::RegWidth,  0, 20'h0,     0, 16'h0, 0},
    '{DoConfig,  awbs_pkg::RegHeight, 0, 20'h3FF,   0, 16'h0, 0},
    '{DoConfig,  awbs_pkg::RegShiftX, 0, 20'h400,   0, 16'h0, 0},
    '{DoRequest, 0,   0,   20'h0,  1, 16'h0, 0},
    '{DoConfig,  awbs_pkg::RegShiftX, 0, 20'h0,     0, 16'h0, 0},
    '{DoConfig,  awbs_pkg::RegMatXx,  0, 20'h80000, 0, 16'h0, 0},
    '{DoRequest, 511, 0,   20'h0,  1, 16'h0, 0},
    '{DoConfig,  awbs_pkg::RegMatXx,  0, 20'h7FFFF, 0, 16'h0, 0},
    '{DoRequest, 511, 0,   20'h0,  1, 16'h0, 0},
    '{DoConfig,  awbs_pkg::RegShiftY, 0, 20'h3FFFF, 0, 16'h0, 0},
    '{DoRequest, 0,   0,   20'h0,  1, 16'h0, 0},
    '{DoConfig,  awbs_pkg::RegShiftY, 0, 20'h40000, 0, 16'h0, 0},
    '{DoRequest, 0,   0,   20'h0,  1, 16'h0, 0}
  };

  initial begin
    int w, h, col, row, phase;
    bit rd;
    px_res_t pr;
    px_res_t tr;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].op == DoConfig) begin
        drain();
        cfg_write(3'(dir_tbl[i].a), dir_tbl[i].d);
        cfg_done();
      end else begin
        if (dir_tbl[i].op == DoRequest) begin
          tr.sample = dir_tbl[i].t_sample;
          tr.valid = dir_tbl[i].t_valid;
          typed_q.push_back(dir_tbl[i].typed);
          typed_val_q.push_back(tr);
        end
        send(dir_tbl[i].op == DoRequest, dir_tbl[i].a, dir_tbl[i].b, int'(dir_tbl[i].d));
      end
    end

    phase = 0;
    while (n_items < 1950) begin
      drain();
      case ($urandom_range(0, 7))
        0: begin w = $urandom_range(0, 2); h = $urandom_range(3, 10); end
        1: begin w = ($urandom_range(0, 1) != 0) ? 1023 : 512; h = $urandom_range(0, 5); end
        2: begin w = $urandom_range(3, 8); h = ($urandom_range(0, 1) != 0) ? 512 : 1023; end
        default: begin w = $urandom_range(3, 14); h = $urandom_range(3, 14); end
      endcase
      cfg_write(awbs_pkg::RegMatXx, rand_mat());
      cfg_write(awbs_pkg::RegMatXy, rand_mat());
      cfg_write(awbs_pkg::RegMatYx, rand_mat());
      cfg_write(awbs_pkg::RegMatYy, rand_mat());
      cfg_write(awbs_pkg::RegShiftX, rand_shift(clampi(w, awbs_pkg::MaxWidth)));
      cfg_write(awbs_pkg::RegShiftY, rand_shift(clampi(h, awbs_pkg::MaxHeight)));
      cfg_write(awbs_pkg::RegWidth, 20'(w));
      cfg_write(awbs_pkg::RegHeight, 20'(h));
      cfg_done();
      w = clampi(w, awbs_pkg::MaxWidth);
      h = clampi(h, awbs_pkg::MaxHeight);
      if (w * h <= 400) begin
        for (int r = 0; r < h; r++)
          for (int c = 0; c < w; c++) send(0, c, r, $urandom_range(0, 255));
      end else begin
        repeat (300) send(0, $urandom_range(0, w - 1), $urandom_range(0, h - 1), $urandom);
      end
      repeat (140) begin
        if ($urandom_range(0, 9) < 7) begin
          if ($urandom_range(0, 4) == 0) begin
            col = $urandom_range(0, 511);
            row = $urandom_range(0, 511);
          end else begin
            col = $urandom_range(0, (w + 2 > 511) ? 511 : w + 2);
            row = $urandom_range(0, (h + 2 > 511) ? 511 : h + 2);
          end
          warp_pixel(col, row, rd, pr);
          if (rd) send(1, col, row, $urandom);
          else send(0, $urandom_range(0, w - 1), $urandom_range(0, h - 1), $urandom);
        end else if ($urandom_range(0, 3) == 0) begin
          send(0, $urandom_range(0, 511), $urandom_range(0, 511), $urandom);
        end else begin
          send(0, $urandom_range(0, w - 1), $urandom_range(0, h - 1), $urandom);
        end
      end
      phase++;
    end

    drain();
    $display("covered %0d transactions: %0d pixel writes, %0d warp requests (%0d in range)",
             n_items, n_write, n_req, n_valid);
    $display("%0d register writes over %0d random settings plus directed extremes",
             n_cfg, phase);
    if (errors == 0) begin
      $display("affine_warp_bilinear_sampler_unit verification clean");
    end else begin
      $display("affine_warp_bilinear_sampler_unit verification failed");
    end
    $finish;
  end

endmodule
